// ----- hdl/lzsswd_pkg.sv -----
package lzsswd_pkg;

   localparam int unsigned ADDR_W = 12;
   localparam int unsigned FILL_W = ADDR_W + 1;

   localparam logic [ADDR_W-1:0] WIN_START    = 12'hFEE;
   localparam logic [3:0]        GROUP_TOKENS = 4'd8;
   localparam logic [4:0]        MIN_COPY_M1  = 5'd2;

   typedef enum logic [1:0] {
      CMD_NOP,
      CMD_LIT,
      CMD_COPY
   } cmd_kind_type;

   // One queued operation for the copy engine. For a literal, data is the byte.
   // For a copy, data is the low offset byte and offset_hi the top nibble.
   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data;
      logic [3:0]   offset_hi;
      logic [3:0]   len_nib;
      logic         stream_end;
   } cmd_type;

endpackage

// ----- hdl/lzsswd_front.sv -----
module lzsswd_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           code_byte,
   input  logic                 stream_end,
   output logic                 push,
   output lzsswd_pkg::cmd_type  cmd
);

   typedef enum logic [1:0] {
      PH_FLAG,
      PH_TOKEN,
      PH_HIGH
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] flags_ff, flags_in;
   logic [3:0] tokens_ff, tokens_in;
   logic [7:0] held_ff, held_in;
   logic [3:0] tokens_dec;

   assign tokens_dec = tokens_ff - 4'd1;

   always_comb begin
      phase_in  = phase_ff;
      flags_in  = flags_ff;
      tokens_in = tokens_ff;
      held_in   = held_ff;
      push      = 1'b0;
      cmd.kind       = lzsswd_pkg::CMD_NOP;
      cmd.data       = code_byte;
      cmd.offset_hi  = code_byte[7:4];
      cmd.len_nib    = code_byte[3:0];
      cmd.stream_end = stream_end;
      if (accept) begin
         case (phase_ff)
            PH_TOKEN: begin
               if (flags_ff[0]) begin
                  push      = 1'b1;
                  cmd.kind  = lzsswd_pkg::CMD_LIT;
                  flags_in  = {1'b0, flags_ff[7:1]};
                  tokens_in = tokens_dec;
                  phase_in  = (tokens_dec == 4'd0) ? PH_FLAG : PH_TOKEN;
               end else begin
                  held_in  = code_byte;
                  phase_in = PH_HIGH;
                  push     = stream_end;
               end
            end
            PH_HIGH: begin
               push      = 1'b1;
               cmd.kind  = lzsswd_pkg::CMD_COPY;
               cmd.data  = held_ff;
               flags_in  = {1'b0, flags_ff[7:1]};
               tokens_in = tokens_dec;
               phase_in  = (tokens_dec == 4'd0) ? PH_FLAG : PH_TOKEN;
            end
            default: begin
               flags_in  = code_byte;
               tokens_in = lzsswd_pkg::GROUP_TOKENS;
               phase_in  = PH_TOKEN;
               push      = stream_end;
            end
         endcase
         // The end of a stream drops any partial token and starts over.
         if (stream_end) begin
            phase_in  = PH_FLAG;
            flags_in  = 8'd0;
            tokens_in = 4'd0;
            held_in   = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_FLAG;
         flags_ff  <= 8'd0;
         tokens_ff <= 4'd0;
         held_ff   <= 8'd0;
      end else begin
         phase_ff  <= phase_in;
         flags_ff  <= flags_in;
         tokens_ff <= tokens_in;
         held_ff   <= held_in;
      end
   end

endmodule

// ----- hdl/lzsswd_queue.sv -----
module lzsswd_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  lzsswd_pkg::cmd_type  push_cmd,
   input  logic                 pop,
   output lzsswd_pkg::cmd_type  head,
   output logic                 empty,
   output logic                 full
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   lzsswd_pkg::cmd_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == FULL_CNT);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- hdl/lzsswd_back.sv -----
module lzsswd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  lzsswd_pkg::cmd_type  q_head,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_run_last
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EMIT
   } state_type;

   localparam int unsigned AW = lzsswd_pkg::ADDR_W;
   localparam int unsigned FW = lzsswd_pkg::FILL_W;
   localparam int unsigned WIN_DEPTH = 1 << AW;

   state_type           state_ff, state_in;
   lzsswd_pkg::cmd_type cur_ff, cur_in;
   logic [AW-1:0]       pos_ff, pos_in;
   logic [FW-1:0]       fill_ff, fill_in;
   logic [AW-1:0]       rd_addr_ff, rd_addr_in;
   logic [4:0]          remain_ff, remain_in;
   logic                hit_ff, hit_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_byte_ff, rsp_byte_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [7:0]          hist_mem [WIN_DEPTH];
   logic [7:0]          rd_data_ff;
   logic                mem_we;
   logic [7:0]          wbyte;
   logic                out_free;
   logic                last_byte;
   logic [AW-1:0]       rel_addr;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_run_last = rsp_last_ff;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rel_addr  = rd_addr_ff - lzsswd_pkg::WIN_START;
   assign last_byte = (cur_ff.kind == lzsswd_pkg::CMD_LIT) || (remain_ff == 5'd0);
   // Bytes are written in order from the start position, so an entry holds
   // stream data exactly when it lies within the fill count; otherwise it is zero.
   assign wbyte = (cur_ff.kind == lzsswd_pkg::CMD_LIT) ? cur_ff.data :
                  (hit_ff ? rd_data_ff : 8'd0);

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      pos_in       = pos_ff;
      fill_in      = fill_ff;
      rd_addr_in   = rd_addr_ff;
      remain_in    = remain_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               cur_in = q_head;
               case (q_head.kind)
                  lzsswd_pkg::CMD_LIT: begin
                     state_in = ST_EMIT;
                  end
                  lzsswd_pkg::CMD_COPY: begin
                     rd_addr_in = {q_head.offset_hi, q_head.data};
                     remain_in  = {1'b0, q_head.len_nib} + lzsswd_pkg::MIN_COPY_M1;
                     state_in   = ST_READ;
                  end
                  default: begin
                     if (q_head.stream_end) begin
                        pos_in  = lzsswd_pkg::WIN_START;
                        fill_in = '0;
                     end
                  end
               endcase
            end
         end
         ST_READ: begin
            hit_in   = ({1'b0, rel_addr} < fill_ff);
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               mem_we       = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_byte_in  = wbyte;
               rsp_last_in  = last_byte;
               pos_in       = pos_ff + AW'(1);
               fill_in      = fill_ff[FW-1] ? fill_ff : fill_ff + FW'(1);
               if (last_byte) begin
                  state_in = ST_IDLE;
                  if (cur_ff.stream_end) begin
                     pos_in  = lzsswd_pkg::WIN_START;
                     fill_in = '0;
                  end
               end else begin
                  remain_in  = remain_ff - 5'd1;
                  rd_addr_in = rd_addr_ff + AW'(1);
                  state_in   = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= lzsswd_pkg::WIN_START;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff      <= cur_in;
      rd_addr_ff  <= rd_addr_in;
      remain_ff   <= remain_in;
      hit_ff      <= hit_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[pos_ff] <= wbyte;
      end
      if (state_ff == ST_READ) begin
         rd_data_ff <= hist_mem[rd_addr_ff];
      end
   end

endmodule

// ----- hdl/lzss_window_decoder_core.sv -----
// Each input word is classified in the cycle it is accepted; literal and high bytes are queued as one operation each.
// In the copy engine a literal is popped and written out; a back-reference is popped and then
// takes one history read and one history write per output byte. Flag and low bytes are queued
// only when they end a stream, and then take no engine work beyond the pop.
// A result word passes through the queue slot, the engine's operation register and the output register.
// Synchronous reset returns to the start of a stream; the history window reads as zero
// through a fill count, so neither reset nor a stream end needs a clearing pass.
module lzss_window_decoder_core #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_code_byte,
   input  logic       req_stream_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last
);

   logic                req_accept;
   logic                q_push;
   lzsswd_pkg::cmd_type q_push_cmd;
   logic                q_pop;
   lzsswd_pkg::cmd_type q_head;
   logic                q_empty;
   logic                q_full;

   assign req_ready  = !q_full;
   assign req_accept = req_valid && req_ready;

   lzsswd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .code_byte  (req_code_byte),
      .stream_end (req_stream_end),
      .push       (q_push),
      .cmd        (q_push_cmd)
   );

   lzsswd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_push_cmd),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty),
      .full     (q_full)
   );

   lzsswd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_run_last (rsp_run_last)
   );

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("queue popped while empty");

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("queue pushed while full");

   a_reset_clean: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> (!rsp_valid && q_empty))
      else $error("state not clean after reset");

endmodule

// ----- test/lzss_window_decoder_checker.sv -----
module lzss_window_decoder_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_code_byte,
   input  logic       req_stream_end,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_run_last,
   output int         mismatches,
   output int         bytes_pending
);

   typedef enum logic [1:0] {
      EXPECT_FLAG,
      EXPECT_TOKEN,
      EXPECT_HIGH
   } parse_phase_type;

   typedef struct packed {
      logic [7:0] value;
      logic       run_last;
   } out_byte_type;

   localparam int unsigned WINDOW_BYTES = 4096;
   localparam logic [4:0]  SHORTEST_COPY = 5'd3;

   logic [7:0]      window [WINDOW_BYTES];
   logic [11:0]     write_pos;
   logic [7:0]      flag_bits;
   logic [3:0]      tokens_left;
   parse_phase_type phase;
   logic [7:0]      held_low;
   out_byte_type    expected_bytes [$];

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 40) begin
         $display("ERROR at %0t: %s", $time, what);
      end
   endtask

   task automatic restart_stream();
      for (int i = 0; i < WINDOW_BYTES; i++) begin
         window[i] = 8'h00;
      end
      write_pos = lzsswd_pkg::WIN_START;
      flag_bits = 8'h00;
      tokens_left = 4'd0;
      phase = EXPECT_FLAG;
      held_low = 8'h00;
   endtask

   task automatic append_byte(input logic [7:0] value);
      window[write_pos] = value;
      write_pos = write_pos + 12'd1;
      expected_bytes.push_back('{value: value, run_last: 1'b0});
   endtask

   task automatic token_done();
      flag_bits = flag_bits >> 1;
      tokens_left = tokens_left - 4'd1;
      phase = (tokens_left == 4'd0) ? EXPECT_FLAG : EXPECT_TOKEN;
   endtask

   task automatic decode_word(input logic [7:0] code, input logic fin);
      int unsigned  queued_before;
      logic [11:0]  offset;
      logic [4:0]   copy_len;
      out_byte_type tail;
      queued_before = expected_bytes.size();
      case (phase)
         EXPECT_TOKEN: begin
            if (flag_bits[0]) begin
               append_byte(code);
               token_done();
            end else begin
               held_low = code;
               phase = EXPECT_HIGH;
            end
         end
         EXPECT_HIGH: begin
            offset = {code[7:4], held_low};
            copy_len = {1'b0, code[3:0]} + SHORTEST_COPY;
            // Each byte is written back before the next read, so a copy that
            // overlaps its own output repeats the bytes it just produced.
            for (int j = 0; j < copy_len; j++) begin
               append_byte(window[offset + 12'(j)]);
            end
            token_done();
         end
         default: begin
            flag_bits = code;
            tokens_left = lzsswd_pkg::GROUP_TOKENS;
            phase = EXPECT_TOKEN;
         end
      endcase
      if (expected_bytes.size() > queued_before) begin
         tail = expected_bytes.pop_back();
         tail.run_last = 1'b1;
         expected_bytes.push_back(tail);
      end
      if (fin) begin
         restart_stream();
      end
   endtask

   always @(posedge clock) begin
      out_byte_type want;
      if (reset) begin
         restart_stream();
         expected_bytes.delete();
         mismatches = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch($sformatf("unexpected word out_byte=%02h run_last=%0b",
                                         rsp_out_byte, rsp_run_last));
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_out_byte !== want.value) begin
                  report_mismatch($sformatf("out_byte %02h, predicted %02h",
                                            rsp_out_byte, want.value));
               end
               if (rsp_run_last !== want.run_last) begin
                  report_mismatch($sformatf("run_last %0b, predicted %0b (byte %02h)",
                                            rsp_run_last, want.run_last, want.value));
               end
            end
         end
         if (req_valid && req_ready) begin
            decode_word(req_code_byte, req_stream_end);
         end
      end
      bytes_pending = expected_bytes.size();
   end

endmodule

// ----- test/lzss_window_decoder_core_tb.sv -----
module lzss_window_decoder_core_tb;

   typedef struct packed {
      logic [7:0] code;
      logic       fin;
   } code_word_type;

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_COIN,
      RX_SPARSE,
      RX_PERIODIC
   } rx_mode_type;

   localparam int unsigned WORD_TARGET = 180;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic [7:0] req_code_byte = 8'h00;
   logic       req_stream_end = 1'b0;
   logic       rsp_ready = 1'b0;
   logic       req_ready;
   logic       rsp_valid;
   logic [7:0] rsp_out_byte;
   logic       rsp_run_last;
   int         mismatches;
   int         bytes_pending;

   code_word_type stim_words [$];
   logic [11:0]   gen_pos;

   rx_mode_type rx_mode = RX_OPEN;
   int unsigned rx_cycle = 0;

   lzss_window_decoder_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_code_byte  (req_code_byte),
      .req_stream_end (req_stream_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_last   (rsp_run_last)
   );

   lzss_window_decoder_checker byte_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_code_byte  (req_code_byte),
      .req_stream_end (req_stream_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_last   (rsp_run_last),
      .mismatches     (mismatches),
      .bytes_pending  (bytes_pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("lzss_window_decoder_core: mismatch");
      $finish;
   end

   // The receiver switches among four stall styles, picked at random.
   always @(posedge clock) begin
      if (rx_cycle % 50 == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
      end
      rx_cycle++;
      case (rx_mode)
         RX_OPEN:     rsp_ready <= 1'b1;
         RX_COIN:     rsp_ready <= 1'($urandom_range(0, 1));
         RX_SPARSE:   rsp_ready <= ($urandom_range(0, 4) == 0);
         RX_PERIODIC: rsp_ready <= (rx_cycle % 7 < 4);
         default:     rsp_ready <= 1'b1;
      endcase
   end

   task automatic push_word(input logic [7:0] code, input logic fin);
      stim_words.push_back('{code: code, fin: fin});
   endtask

   task automatic push_ref(input logic [7:0] low, input logic [7:0] high, input logic fin);
      push_word(low, 1'b0);
      push_word(high, fin);
   endtask

   task automatic end_stream_here();
      code_word_type tail;
      tail = stim_words.pop_back();
      tail.fin = 1'b1;
      stim_words.push_back(tail);
   endtask

   task automatic send_word(input logic [7:0] code, input logic fin);
      req_valid <= 1'b1;
      req_code_byte <= code;
      req_stream_end <= fin;
      do @(posedge clock); while (!req_ready);
   endtask

   initial begin
      int unsigned   groups;
      int unsigned   tokens;
      int unsigned   burst;
      int unsigned   gap;
      logic [7:0]    flags;
      logic [3:0]    len_nib;
      logic [11:0]   offset;
      code_word_type w;

      // Literals 00 and FF, then a copy that overlaps its own output, a
      // maximum-length copy across the window wrap, and a stream that ends
      // after a reference low byte.
      push_word(8'h03, 1'b0);
      push_word(8'h00, 1'b0);
      push_word(8'hFF, 1'b0);
      push_ref(8'hEE, 8'hF0, 1'b0);
      push_ref(8'hFF, 8'hFF, 1'b0);
      push_ref(8'h00, 8'h00, 1'b0);
      push_word(8'h12, 1'b1);
      // A stream that ends on its flag byte.
      push_word(8'hFF, 1'b1);
      // A reference first, then a literal that ends the stream.
      push_word(8'hFE, 1'b0);
      push_ref(8'h5A, 8'hA5, 1'b0);
      push_word(8'hA5, 1'b1);
      // A group of references only, into the freshly cleared window.
      push_word(8'h00, 1'b0);
      push_ref(8'hEC, 8'hF7, 1'b0);
      push_ref(8'hF0, 8'h0A, 1'b1);

      while (stim_words.size() < WORD_TARGET) begin
         if ($urandom_range(0, 6) == 0) begin
            // Noise: arbitrary bytes, parsed however the decoder sees them.
            repeat ($urandom_range(3, 20)) push_word(8'($urandom), 1'b0);
            end_stream_here();
         end else begin
            gen_pos = lzsswd_pkg::WIN_START;
            groups = $urandom_range(1, 3);
            for (int g = 0; g < groups; g++) begin
               case ($urandom_range(0, 5))
                  0:       flags = 8'h00;
                  1:       flags = 8'hFF;
                  default: flags = 8'($urandom);
               endcase
               push_word(flags, 1'b0);
               tokens = (g == groups - 1 && $urandom_range(0, 1)) ?
                        $urandom_range(1, 8) : 8;
               for (int t = 0; t < tokens; t++) begin
                  if (flags[t]) begin
                     push_word(8'($urandom), 1'b0);
                     gen_pos = gen_pos + 12'd1;
                  end else begin
                     len_nib = ($urandom_range(0, 4) == 0) ? 4'hF : 4'($urandom);
                     // Mostly point just behind the write position so copies
                     // reuse recent output and often overlap themselves.
                     if ($urandom_range(0, 9) < 7) begin
                        offset = gen_pos - 12'($urandom_range(1, 24));
                     end else begin
                        offset = 12'($urandom);
                     end
                     push_ref(offset[7:0], {offset[11:8], len_nib}, 1'b0);
                     gen_pos = gen_pos + 12'(len_nib) + 12'd3;
                  end
               end
            end
            // Either end on the last token, or add one arbitrary byte that
            // ends the stream on whatever the decoder expects next.
            if ($urandom_range(0, 3) == 0) begin
               push_word(8'($urandom), 1'b1);
            end else begin
               end_stream_here();
            end
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (stim_words.size() > 0) begin
         burst = $urandom_range(1, 16);
         while (burst > 0 && stim_words.size() > 0) begin
            w = stim_words.pop_front();
            send_word(w.code, w.fin);
            burst--;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (bytes_pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      if (mismatches == 0) begin
         $display("lzss_window_decoder_core: match");
      end else begin
         $display("lzss_window_decoder_core: mismatch");
      end
      $finish;
   end

endmodule
